[design/rtps_pkg.sv]
// Shared types, constants and the arctangent table of the rectangle trace sequencer.
package rtps_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned StepW = $clog2(CordicSteps + 1);
  localparam int unsigned XyW = 50;
  localparam int unsigned ZW = 32;
  localparam logic [10:0] AngleMax = 11'd1800;

  localparam logic [1:0] KindStart = 2'd0;
  localparam logic [1:0] KindStop = 2'd1;
  localparam logic [1:0] KindTick = 2'd2;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatZero = 2'd1;
  localparam logic [1:0] StatRange = 2'd2;
  localparam logic [1:0] StatScan = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic [10:0] pan_now;
    logic [10:0] tilt_now;
    logic        scan_active;
    logic        motion_busy;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        move_valid;
    logic [10:0] move_pan;
    logic [10:0] move_tilt;
    logic        stop_motion;
    logic        drawing_active;
    logic        finished;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic sel_h;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic [10:0] angle;
  } dp_stat_t;

  function automatic logic [ZW-1:0] atan_lut(input logic [4:0] idx);
    logic [ZW-1:0] v;
    case (idx)
      5'd0: v = 32'd29491200;   5'd1: v = 32'd17409672;
      5'd2: v = 32'd9198793;    5'd3: v = 32'd4669451;
      5'd4: v = 32'd2343786;    5'd5: v = 32'd1173036;
      5'd6: v = 32'd586661;     5'd7: v = 32'd293348;
      5'd8: v = 32'd146676;     5'd9: v = 32'd73339;
      5'd10: v = 32'd36669;     5'd11: v = 32'd18335;
      5'd12: v = 32'd9167;      5'd13: v = 32'd4584;
      5'd14: v = 32'd2292;      5'd15: v = 32'd1146;
      5'd16: v = 32'd573;       5'd17: v = 32'd286;
      5'd18: v = 32'd143;       5'd19: v = 32'd72;
      5'd20: v = 32'd36;        5'd21: v = 32'd18;
      5'd22: v = 32'd9;         5'd23: v = 32'd4;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[design/rtps_cordic.sv]
// Shared CORDIC vectoring datapath: one rotation step per cycle, atan in tenths.
module rtps_cordic import rtps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  logic [15:0] width_i,
  input  logic [15:0] height_i,
  input  logic [7:0]  dist_i,
  output dp_stat_t    stat_o
);

  logic signed [XyW-1:0] x_q, x_d, y_q, y_d, xs, ys;
  logic signed [ZW-1:0]  z_q, z_d, zt;
  logic [StepW-1:0]      cnt_q, cnt_d;
  logic [15:0]           s;
  logic [ZW-1:0]         zr;

  assign s  = cmd_i.sel_h ? height_i : width_i;
  assign xs = x_q >>> cnt_q;
  assign ys = y_q >>> cnt_q;
  assign zt = $signed(atan_lut(5'(cnt_q)));

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      x_d = $signed({18'd0, dist_i, 24'd0});
      y_d = $signed({10'd0, s, 24'd0});
      z_d = '0;
      cnt_d = '0;
    end else if (cmd_i.step && !stat_o.done) begin
      if (!y_q[XyW-1]) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + zt;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - zt;
      end
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= StepW'(CordicSteps);
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign zr = z_q[ZW-1] ? '0 : ZW'(z_q) + ZW'(32768);
  assign stat_o.done  = (cnt_q == StepW'(CordicSteps));
  assign stat_o.angle = zr[26:16];

endmodule

[design/rtps_ctrl.sv]
// Sequencer controller: item decode, corner state and CORDIC command.
module rtps_ctrl import rtps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data_i,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data_o,
  input  logic [7:0] dist_i,
  output dp_cmd_t   cmd_o,
  input  dp_stat_t  stat_i,
  output logic      idle_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StPan  = 5'b00010,
    StTilt = 5'b00100,
    StFin  = 5'b01000,
    StOut  = 5'b10000
  } state_e;

  state_e      st_q, st_d;
  in_item_t    it_q, it_d;
  out_item_t   res_q, res_d;
  logic [1:0]  phase_q, phase_d, edge_q, edge_d;
  logic [10:0] op_q, op_d, ot_q, ot_d, fp_q, fp_d, ft_q, ft_d;
  logic [11:0] fpan_q, fpan_d, sum;

  localparam logic [1:0] PhIdle = 2'd0, PhStart = 2'd1, PhEdge = 2'd2;

  assign in_ready   = (st_q == StIdle);
  assign out_valid  = (st_q == StOut);
  assign out_data_o = res_q;
  assign idle_o     = (st_q == StIdle);
  assign sum = {1'b0, (st_q == StPan) ? it_q.pan_now : it_q.tilt_now} + {1'b0, stat_i.angle};

  always_comb begin
    st_d = st_q; it_d = it_q; res_d = res_q; phase_d = phase_q; edge_d = edge_q;
    op_d = op_q; ot_d = ot_q; fp_d = fp_q; ft_d = ft_q; fpan_d = fpan_q;
    cmd_o = '0;
    cmd_o.sel_h = (st_q == StPan);
    unique case (st_q)
      StIdle: begin
        if (in_valid) begin
          it_d = in_data_i;
          res_d = '0;
          if (in_data_i.kind == KindStart) begin
            if (in_data_i.rect_width == '0 || in_data_i.rect_height == '0) begin
              res_d.status = StatZero; st_d = StFin;
            end else if (in_data_i.scan_active) begin
              res_d.status = StatScan; st_d = StFin;
            end else if (dist_i == '0) begin
              res_d.status = StatRange; st_d = StFin;
            end else begin
              cmd_o.load = 1'b1; cmd_o.sel_h = 1'b0; st_d = StPan;
            end
          end else if (in_data_i.kind == KindStop) begin
            res_d.stop_motion = 1'b1; phase_d = PhIdle; st_d = StFin;
          end else begin
            if (in_data_i.kind == KindTick && !in_data_i.motion_busy) begin
              if (phase_q == PhStart) begin
                phase_d = PhEdge; edge_d = '0; res_d.move_valid = 1'b1;
                res_d.move_pan = fp_q; res_d.move_tilt = ot_q;
              end else if (phase_q == PhEdge) begin
                if (edge_q != 2'd3) begin
                  edge_d = edge_q + 1'b1; res_d.move_valid = 1'b1;
                  case (edge_q)
                    2'd0: begin res_d.move_pan = fp_q; res_d.move_tilt = ft_q; end
                    2'd1: begin res_d.move_pan = op_q; res_d.move_tilt = ft_q; end
                    default: begin res_d.move_pan = op_q; res_d.move_tilt = ot_q; end
                  endcase
                end else begin
                  phase_d = PhIdle; res_d.finished = 1'b1;
                end
              end
            end
            st_d = StFin;
          end
        end
      end
      StPan: begin
        cmd_o.step = 1'b1;
        if (stat_i.done) begin
          fpan_d = sum;
          cmd_o.step = 1'b0; cmd_o.load = 1'b1; cmd_o.sel_h = 1'b1;
          st_d = StTilt;
        end
      end
      StTilt: begin
        cmd_o.step = 1'b1;
        if (stat_i.done) begin
          cmd_o.step = 1'b0;
          if (fpan_q > {1'b0, AngleMax} || sum > {1'b0, AngleMax}) begin
            res_d.status = StatRange;
          end else begin
            op_d = it_q.pan_now; ot_d = it_q.tilt_now;
            fp_d = fpan_q[10:0]; ft_d = sum[10:0];
            phase_d = PhStart; edge_d = '0;
            res_d.move_valid = 1'b1;
            res_d.move_pan = it_q.pan_now; res_d.move_tilt = it_q.tilt_now;
          end
          st_d = StFin;
        end
      end
      StFin: begin
        res_d.drawing_active = (phase_q != PhIdle);
        st_d = StOut;
      end
      StOut: begin
        if (out_ready) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; phase_q <= PhIdle; edge_q <= '0;
      op_q <= '0; ot_q <= '0; fp_q <= '0; ft_q <= '0;
    end else begin
      st_q <= st_d; phase_q <= phase_d; edge_q <= edge_d;
      op_q <= op_d; ot_q <= ot_d; fp_q <= fp_d; ft_q <= ft_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d; res_q <= res_d; fpan_q <= fpan_d;
  end

endmodule

[design/rectangle_trace_pan_tilt_sequencer_unit.sv]
// Top level of the rectangle trace pan-tilt sequencer.
// Stop, tick and rejected start beats go from idle through the finish state to the
// result beat; a start that passes its checks first runs the one shared CORDIC unit
// for pan, then for tilt. One beat in flight; the next input beat is taken the
// cycle after the result beat leaves.
// Reset: asynchronous active low; phase idle, corners zero, distance 100 cm.
module rectangle_trace_pan_tilt_sequencer_unit import rtps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data_i,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data_o,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0] cfg_data_i
);

  logic [7:0] dist_q;
  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic       idle;
  logic [15:0] h_q;
  logic [15:0] u_ctrl_h;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= 8'd100;
    end else if (cfg_valid) begin
      dist_q <= cfg_data_i;
    end
  end

  rtps_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready, .in_data_i, .out_valid, .out_ready,
    .out_data_o, .dist_i(dist_q), .cmd_o(cmd), .stat_i(stat), .idle_o(idle)
  );

  rtps_cordic u_cordic (
    .clk_i, .rst_ni, .cmd_i(cmd), .width_i(in_ready ? in_data_i.rect_width : '0),
    .height_i(u_ctrl_h), .dist_i(dist_q), .stat_o(stat)
  );

  always_ff @(posedge clk_i) begin
    if (in_valid && in_ready) h_q <= in_data_i.rect_height;
  end
  assign u_ctrl_h = h_q;

  a_no_cross: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid)) else $error("input and output both open");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load && !cmd.sel_h |-> idle) else $error("load outside idle");
  a_out_mv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data_o.move_valid |-> out_data_o.move_pan == '0)
    else $error("move fields not cleared");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the rectangle trace pan-tilt sequencer.
module tb_top;
  import rtps_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data_i = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data_o;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_data_i = '0;

  rectangle_trace_pan_tilt_sequencer_unit i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_valid), .in_ready(in_ready), .in_data_i(in_data_i),
    .out_valid(out_valid), .out_ready(out_ready), .out_data_o(out_data_o),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [7:0]  pred_dist;
  logic [1:0]  pred_phase;
  logic [1:0]  pred_edges;
  logic [10:0] org_pan, org_tilt, far_pan_q, far_tilt_q;

  out_item_t expected_moves[$];
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_wait = 0;
  bit hold_off = 1'b0;

  function automatic longint shr_floor(longint v, int k);
    return v >>> k;
  endfunction

  function automatic logic [31:0] atan_tenths(logic [15:0] s, logic [7:0] d);
    longint x, y, z, xs, ys;
    x = longint'(d) << 24;
    y = longint'(s) << 24;
    z = 0;
    for (int i = 0; i < CordicSteps && i < 24; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += longint'(atan_lut(i[4:0]));
      end else begin
        x = x - ys; y = y + xs; z -= longint'(atan_lut(i[4:0]));
      end
    end
    if (z < 0) z = 0;
    return 32'((z + 32768) >> 16);
  endfunction

  function automatic out_item_t predict_move(in_item_t it);
    out_item_t r;
    logic [31:0] fp, ft;
    r = '0;
    if (it.kind == KindStart) begin
      if (it.rect_width == 0 || it.rect_height == 0) r.status = StatZero;
      else if (it.scan_active) r.status = StatScan;
      else if (pred_dist == 0) r.status = StatRange;
      else begin
        fp = 32'(it.pan_now) + atan_tenths(it.rect_width, pred_dist);
        ft = 32'(it.tilt_now) + atan_tenths(it.rect_height, pred_dist);
        if (fp > 32'(AngleMax) || ft > 32'(AngleMax)) r.status = StatRange;
        else begin
          org_pan = it.pan_now; org_tilt = it.tilt_now;
          far_pan_q = fp[10:0]; far_tilt_q = ft[10:0];
          pred_phase = 2'd1; pred_edges = 0;
          r.move_valid = 1; r.move_pan = org_pan; r.move_tilt = org_tilt;
        end
      end
    end else if (it.kind == KindStop) begin
      r.stop_motion = 1; pred_phase = 2'd0;
    end else if (it.kind == KindTick && !it.motion_busy) begin
      if (pred_phase == 2'd1) begin
        pred_phase = 2'd2; pred_edges = 0;
        r.move_valid = 1; r.move_pan = far_pan_q; r.move_tilt = org_tilt;
      end else if (pred_phase == 2'd2) begin
        if (pred_edges < 3) begin
          pred_edges++;
          r.move_valid = 1;
          case (pred_edges)
            2'd1: begin r.move_pan = far_pan_q; r.move_tilt = far_tilt_q; end
            2'd2: begin r.move_pan = org_pan; r.move_tilt = far_tilt_q; end
            default: begin r.move_pan = org_pan; r.move_tilt = org_tilt; end
          endcase
        end else begin
          pred_phase = 2'd0; r.finished = 1;
        end
      end
    end
    r.drawing_active = (pred_phase != 2'd0);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    mismatches++;
  endtask

  task automatic send_item(in_item_t it);
    repeat ($urandom_range(0, 9)) @(posedge clk_i);
    in_valid <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready);
    expected_moves.push_back(predict_move(it));
    in_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    while (expected_moves.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_distance(logic [7:0] d);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pred_dist = d;
  endtask

  function automatic in_item_t make_start(logic [15:0] w, logic [15:0] h,
                                          logic [10:0] p, logic [10:0] t, bit scan);
    in_item_t it;
    it = '0;
    it.kind = KindStart; it.rect_width = w; it.rect_height = h;
    it.pan_now = p; it.tilt_now = t; it.scan_active = scan;
    return it;
  endfunction

  function automatic in_item_t make_tick(bit busy);
    in_item_t it;
    it = $urandom();
    it.kind = KindTick; it.motion_busy = busy;
    return it;
  endfunction

  function automatic in_item_t make_stop();
    in_item_t it;
    it = $urandom();
    it.kind = KindStop;
    return it;
  endfunction

  task automatic run_trace(in_item_t st);
    send_item(st);
    repeat (6) send_item(make_tick($urandom_range(0, 3) == 0));
  endtask

  task automatic test_directed();
    send_item(make_tick(0));
    send_item(make_stop());
    send_item(make_start(0, 5, 0, 0, 0));
    send_item(make_start(5, 0, 0, 0, 0));
    send_item(make_start(10, 10, 0, 0, 1));
    send_item(make_start(16'hFFFF, 1, 0, 0, 0));
    send_item(make_start(1, 1, 1800, 0, 0));
    send_item(make_start(1, 1, 11'h7FF, 11'h7FF, 0));
    send_item(make_start(50, 80, 100, 200, 0));
    repeat (5) send_item(make_tick(0));
    send_item(make_start(20, 20, 300, 300, 0));
    send_item(make_tick(1));
    send_item(make_tick(0));
    send_item(make_start(30, 40, 0, 0, 0));
    send_item(make_stop());
    begin
      in_item_t k3;
      k3 = '1;
      send_item(k3);
    end
  endtask

  task automatic test_random(int n);
    int i;
    in_item_t it;
    i = 0;
    while (i < n) begin
      case ($urandom_range(0, 9))
        0: begin it = $urandom(); send_item(it); i++; end
        1: begin it = $urandom(); it.kind = KindStart; send_item(it); i++; end
        default: begin
          it = make_start($urandom_range(1, 400), $urandom_range(1, 400),
                          $urandom_range(0, 1800), $urandom_range(0, 1800),
                          $urandom_range(0, 15) == 0);
          if ($urandom_range(0, 7) == 0) it.rect_width = $urandom();
          run_trace(it);
          if ($urandom_range(0, 5) == 0) send_item(make_stop());
          i += 7;
        end
      endcase
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    repeat (8) send_item(make_tick(0));
    run_trace(make_start(10, 10, 0, 0, 0));
    hold_off = 1'b0;
    drain_results();
  endtask

  initial begin
    pred_dist = 8'd100; pred_phase = 0; pred_edges = 0;
    org_pan = 0; org_tilt = 0; far_pan_q = 0; far_tilt_q = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_distance(8'd0);
    send_item(make_start(10, 10, 0, 0, 0));
    write_distance(8'd255);
    test_directed();
    test_random(200);
    write_distance(8'd10);
    test_random(200);
    write_distance(8'd1);
    test_random(150);
    write_distance(8'd200);
    test_random(200);
    test_backpressure();
    write_distance(8'd100);
    test_random(300);
    drain_results();
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // receiver: random wait per beat, plus one long hold-off
  always @(posedge clk_i) begin
    int unsigned w;
    if (hold_off && stall_cycles < 400) begin
      stall_cycles <= stall_cycles + 1;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      w = $urandom_range(0, 9);
      rx_wait <= w;
      out_ready <= (w == 0);
    end else if (rx_wait != 0) begin
      if (out_valid) rx_wait <= rx_wait - 1;
      out_ready <= out_valid && (rx_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_moves.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = expected_moves.pop_front();
        if (out_data_o.status != want.status)
          report_mismatch("status", out_data_o.status, want.status);
        if (out_data_o.move_valid != want.move_valid)
          report_mismatch("move_valid", out_data_o.move_valid, want.move_valid);
        if (out_data_o.move_pan != want.move_pan)
          report_mismatch("move_pan", out_data_o.move_pan, want.move_pan);
        if (out_data_o.move_tilt != want.move_tilt)
          report_mismatch("move_tilt", out_data_o.move_tilt, want.move_tilt);
        if (out_data_o.stop_motion != want.stop_motion)
          report_mismatch("stop_motion", out_data_o.stop_motion, want.stop_motion);
        if (out_data_o.drawing_active != want.drawing_active)
          report_mismatch("drawing_active", out_data_o.drawing_active,
                          want.drawing_active);
        if (out_data_o.finished != want.finished)
          report_mismatch("finished", out_data_o.finished, want.finished);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("== FAIL ==");
      $finish;
    end
  end
endmodule

[rectangle_trace_pan_tilt_sequencer_unit.f]
design/rtps_pkg.sv
design/rtps_cordic.sv
design/rtps_ctrl.sv
design/rectangle_trace_pan_tilt_sequencer_unit.sv
tb/tb_top.sv
